### hdl/sta_pkg.sv
// Package for the strided tensor address generator.
// Holds field widths and configuration register indexes; no dependencies.
`default_nettype none
package sta_pkg;
    localparam int SIZE_W   = 16;
    localparam int STRIDE_W = 32;
    localparam int ADDR_W   = 50;
    localparam int PROD_W   = SIZE_W + STRIDE_W;
    localparam int IN_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int NUM_AXES = 3;

    localparam logic [CFG_IDX_W-1:0] REG_RANK    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE1 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE2 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BASE    = 3'd7;

    typedef logic [SIZE_W-1:0]   t_size;
    typedef logic [STRIDE_W-1:0] t_stride;
    typedef logic [ADDR_W-1:0]   t_addr;
endpackage
`default_nettype wire

### hdl/sta_div_cell.sv
// One restoring division step: produces one quotient bit per cell.
// Depends on sta_pkg.
`default_nettype none
module sta_div_cell #(
    parameter int W = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  wire [W-1:0]         i_quo,
    input  sta_pkg::t_size      i_rem,
    input  sta_pkg::t_size      i_div,
    input  sta_pkg::t_addr      i_addr,
    output logic                o_valid,
    output logic [W-1:0]        o_quo,
    output sta_pkg::t_size      o_rem,
    output sta_pkg::t_addr      o_addr
);
    logic [sta_pkg::SIZE_W:0]   trial;
    logic [sta_pkg::SIZE_W:0]   diff;
    logic                       ge;

    assign trial = {i_rem, i_quo[W-1]};
    assign ge    = trial >= {1'b0, i_div};
    assign diff  = trial - {1'b0, i_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_quo  <= {i_quo[W-2:0], ge};
            o_rem  <= ge ? diff[sta_pkg::SIZE_W-1:0] : trial[sta_pkg::SIZE_W-1:0];
            o_addr <= i_addr;
        end
    end
endmodule
`default_nettype wire

### hdl/sta_axis.sv
// One tensor axis: a chain of division cells, a multiply stage and an add stage.
// Depends on sta_pkg and sta_div_cell.
`default_nettype none
module sta_axis #(
    parameter int W = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_active,
    input  sta_pkg::t_size      i_size,
    input  sta_pkg::t_stride    i_stride,
    input  wire                 i_valid,
    input  wire [W-1:0]         i_rest,
    input  sta_pkg::t_addr      i_addr,
    output logic                o_valid,
    output logic [W-1:0]        o_rest,
    output sta_pkg::t_addr      o_addr
);
    logic                       c_valid [W+1];
    logic [W-1:0]               c_quo   [W+1];
    sta_pkg::t_size             c_rem   [W+1];
    sta_pkg::t_addr             c_addr  [W+1];
    sta_pkg::t_size             div;
    logic                       zero;
    logic                       r_mvalid;
    logic [W-1:0]               r_mrest;
    logic [sta_pkg::PROD_W-1:0] r_prod;
    sta_pkg::t_addr             r_maddr;

    // Inactive axes divide by one so the index passes through unchanged.
    assign div  = i_active ? i_size : sta_pkg::t_size'(1);
    assign zero = i_active && (i_size == '0);

    assign c_valid[0] = i_valid;
    assign c_quo[0]   = i_rest;
    assign c_rem[0]   = '0;
    assign c_addr[0]  = i_addr;

    for (genvar k = 0; k < W; k++) begin : g_cell
        sta_div_cell #(.W(W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (c_valid[k]),
            .i_quo   (c_quo[k]),
            .i_rem   (c_rem[k]),
            .i_div   (div),
            .i_addr  (c_addr[k]),
            .o_valid (c_valid[k+1]),
            .o_quo   (c_quo[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_addr  (c_addr[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
            o_valid  <= 1'b0;
        end else if (i_en) begin
            r_mvalid <= c_valid[W];
            o_valid  <= r_mvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mrest <= zero ? '0 : c_quo[W];
            r_prod  <= zero ? '0 : sta_pkg::PROD_W'(c_rem[W]) * sta_pkg::PROD_W'(i_stride);
            r_maddr <= c_addr[W];
            o_rest  <= r_mrest;
            o_addr  <= r_maddr + sta_pkg::t_addr'(r_prod);
        end
    end
endmodule
`default_nettype wire

### hdl/strided_tensor_address.sv
// Strided tensor address generator, top level. Depends on sta_pkg and sta_axis.
// Each axis is pipelined as one division cell per index bit, then a multiply stage
// and an add stage; MAX_RANK axes are chained from input to output transaction.
// Throughput: one transaction per cycle; the whole pipeline holds when the output stalls.
// Reset is synchronous and active low; it clears valid bits and resets the configuration registers.
`default_nettype none
module strided_tensor_address #(
    parameter int MAX_RANK    = 3,
    parameter int INDEX_WIDTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire [2:0]   i_cfg_addr,
    input  wire [31:0]  i_cfg_wdata,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [31:0]  s_axis_tdata,   // [31:0] logical_index
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [55:0] m_axis_tdata    // [49:0] physical_address, rest zero
);
    logic [1:0]         r_rank;
    sta_pkg::t_size     r_size   [sta_pkg::NUM_AXES];
    sta_pkg::t_stride   r_stride [sta_pkg::NUM_AXES];
    logic [31:0]        r_base;
    logic               en;
    logic [63:0]        in_ext;

    logic                   a_valid [MAX_RANK+1];
    logic [INDEX_WIDTH-1:0] a_rest  [MAX_RANK+1];
    sta_pkg::t_addr         a_addr  [MAX_RANK+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank      <= '0;
            r_size[0]   <= 16'd1;
            r_size[1]   <= 16'd1;
            r_size[2]   <= 16'd1;
            r_stride[0] <= '0;
            r_stride[1] <= '0;
            r_stride[2] <= 32'd1;
            r_base      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sta_pkg::REG_RANK:    r_rank      <= i_cfg_wdata[1:0];
                sta_pkg::REG_SIZE0:   r_size[0]   <= i_cfg_wdata[15:0];
                sta_pkg::REG_SIZE1:   r_size[1]   <= i_cfg_wdata[15:0];
                sta_pkg::REG_SIZE2:   r_size[2]   <= i_cfg_wdata[15:0];
                sta_pkg::REG_STRIDE0: r_stride[0] <= i_cfg_wdata;
                sta_pkg::REG_STRIDE1: r_stride[1] <= i_cfg_wdata;
                sta_pkg::REG_STRIDE2: r_stride[2] <= i_cfg_wdata;
                sta_pkg::REG_BASE:    r_base      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign in_ext        = {32'd0, s_axis_tdata};

    // Axes run innermost first; axis MAX_RANK-1 is the first stage.
    assign a_valid[MAX_RANK] = s_axis_tvalid;
    assign a_rest[MAX_RANK]  = in_ext[INDEX_WIDTH-1:0];
    assign a_addr[MAX_RANK]  = sta_pkg::t_addr'(r_base);

    for (genvar j = 0; j < MAX_RANK; j++) begin : g_axis
        sta_axis #(.W(INDEX_WIDTH)) u_axis (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_active ({30'd0, r_rank} > j),
            .i_size   (r_size[j]),
            .i_stride (r_stride[j]),
            .i_valid  (a_valid[j+1]),
            .i_rest   (a_rest[j+1]),
            .i_addr   (a_addr[j+1]),
            .o_valid  (a_valid[j]),
            .o_rest   (a_rest[j]),
            .o_addr   (a_addr[j])
        );
    end

    assign m_axis_tvalid = a_valid[0];
    assign m_axis_tdata  = {6'd0, a_addr[0]};

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("pipeline stalled with empty output");
endmodule
`default_nettype wire

### dv/strided_tensor_address_tb.sv
// Testbench for the strided tensor address generator: drives logical indexes
// over the input stream and checks each physical address against a predictor.
// Depends on sta_pkg and the strided_tensor_address RTL.
`timescale 1ns / 1ps
`default_nettype none

module strided_tensor_address_tb;

    class addr_scoreboard;
        logic [1:0]       rank;
        sta_pkg::t_size   sizes [sta_pkg::NUM_AXES];
        sta_pkg::t_stride strides [sta_pkg::NUM_AXES];
        sta_pkg::t_stride base;
        sta_pkg::t_addr   pending [$];
        int               errors;

        function new();
            errors = 0;
            reset_regs();
        endfunction

        function void reset_regs();
            rank = 0;
            sizes[0] = 1;
            sizes[1] = 1;
            sizes[2] = 1;
            strides[0] = 0;
            strides[1] = 0;
            strides[2] = 1;
            base = 0;
        endfunction

        function void write_reg(logic [sta_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                sta_pkg::REG_RANK:    rank = val[1:0];
                sta_pkg::REG_SIZE0:   sizes[0] = val[15:0];
                sta_pkg::REG_SIZE1:   sizes[1] = val[15:0];
                sta_pkg::REG_SIZE2:   sizes[2] = val[15:0];
                sta_pkg::REG_STRIDE0: strides[0] = val;
                sta_pkg::REG_STRIDE1: strides[1] = val;
                sta_pkg::REG_STRIDE2: strides[2] = val;
                sta_pkg::REG_BASE:    base = val;
                default: ;
            endcase
        endfunction

        function sta_pkg::t_addr map_index(logic [31:0] index);
            logic [63:0] rest;
            logic [63:0] coord;
            logic [63:0] sum;
            int          n;
            rest = {32'd0, index};
            sum = {32'd0, base};
            n = (rank > sta_pkg::NUM_AXES) ? sta_pkg::NUM_AXES : rank;
            for (int a = n - 1; a >= 0; a--) begin
                if (sizes[a] == 0) begin
                    coord = 0;
                    rest = 0;
                end else begin
                    coord = rest % sizes[a];
                    rest = rest / sizes[a];
                end
                sum = sum + coord * strides[a];
            end
            return sum[sta_pkg::ADDR_W-1:0];
        endfunction

        function void note_index(logic [31:0] index);
            pending.push_back(map_index(index));
        endfunction

        function void check_address(logic [55:0] data);
            sta_pkg::t_addr want;
            if (pending.size() == 0) begin
                report_error($sformatf("unexpected address %h", data));
            end else begin
                want = pending.pop_front();
                if (data[sta_pkg::ADDR_W-1:0] !== want)
                    report_error($sformatf("address %h, expected %h",
                        data[sta_pkg::ADDR_W-1:0], want));
                if (data[55:sta_pkg::ADDR_W] !== 0)
                    report_error($sformatf("padding bits %h not zero",
                        data[55:sta_pkg::ADDR_W]));
            end
        endfunction

        function void report_error(string msg);
            errors++;
            if (errors <= 50)
                $display("ERROR at %0t: %s", $time, msg);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_addr;
    logic [31:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;

    addr_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  quiet_cycles = 0;
    bit  timed_out = 1'b0;

    localparam int LATENCY = 3 * (32 + 2);
    localparam int WATCHDOG_LIMIT = 20000;

    strided_tensor_address uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Receiver side: random stalls, result check, and the no-progress watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_address(m_axis_tdata);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_index(input logic [31:0] index);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= index;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.note_index(index);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_size();
        case ($urandom_range(9))
            0: return 0;
            1: return 1;
            2: return 16'hFFFF;
            3: return $urandom_range(65535);
            default: return $urandom_range(2, 40);
        endcase
    endfunction

    function automatic logic [31:0] pick_stride();
        case ($urandom_range(5))
            0: return 0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(1, 4096);
        endcase
    endfunction

    task automatic random_config();
        write_reg(sta_pkg::REG_RANK, $urandom_range(3));
        write_reg(sta_pkg::REG_SIZE0, pick_size());
        write_reg(sta_pkg::REG_SIZE1, pick_size());
        write_reg(sta_pkg::REG_SIZE2, pick_size());
        write_reg(sta_pkg::REG_STRIDE0, pick_stride());
        write_reg(sta_pkg::REG_STRIDE1, pick_stride());
        write_reg(sta_pkg::REG_STRIDE2, pick_stride());
        write_reg(sta_pkg::REG_BASE, ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom);
    endtask

    function automatic logic [31:0] pick_index();
        logic [31:0] span;
        span = 1;
        for (int a = 0; a < sb.rank; a++)
            span = span * ((sb.sizes[a] == 0) ? 1 : sb.sizes[a]);
        case ($urandom_range(7))
            0: return $urandom;
            1: return 32'hFFFF_FFFF;
            2: return 0;
            default: return (span == 0) ? $urandom : $urandom_range(span - 1);
        endcase
    endfunction

    initial begin
        sb = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values, then rank zero with a base at its top value.
        send_index(32'd0);
        send_index(32'hFFFF_FFFF);
        drain();
        write_reg(sta_pkg::REG_BASE, 32'hFFFF_FFFF);
        send_index(32'h1234_5678);
        drain();

        // Full rank, largest sizes and strides: the widest possible address.
        write_reg(sta_pkg::REG_RANK, 2'd3);
        write_reg(sta_pkg::REG_SIZE0, 16'hFFFF);
        write_reg(sta_pkg::REG_SIZE1, 16'hFFFF);
        write_reg(sta_pkg::REG_SIZE2, 16'hFFFF);
        write_reg(sta_pkg::REG_STRIDE0, 32'hFFFF_FFFF);
        write_reg(sta_pkg::REG_STRIDE1, 32'hFFFF_FFFF);
        write_reg(sta_pkg::REG_STRIDE2, 32'hFFFF_FFFF);
        send_index(32'hFFFF_FFFF);
        send_index(32'hFFFE_FFFF);
        send_index(32'h0001_0000);
        send_index(32'd0);
        drain();

        // Small shape with an index beyond the view, then a zero-sized middle axis and lower ranks.
        write_reg(sta_pkg::REG_SIZE0, 16'd3);
        write_reg(sta_pkg::REG_SIZE1, 16'd4);
        write_reg(sta_pkg::REG_SIZE2, 16'd5);
        write_reg(sta_pkg::REG_STRIDE0, 32'd100);
        write_reg(sta_pkg::REG_STRIDE1, 32'd10);
        write_reg(sta_pkg::REG_STRIDE2, 32'd1);
        write_reg(sta_pkg::REG_BASE, 32'd7);
        send_index(32'd59);
        send_index(32'd60);
        send_index(32'd1000);
        drain();
        write_reg(sta_pkg::REG_SIZE1, 16'd0);
        send_index(32'd59);
        send_index(32'hFFFF_FFFF);
        drain();
        write_reg(sta_pkg::REG_RANK, 2'd1);
        send_index(32'd7);
        drain();
        write_reg(sta_pkg::REG_RANK, 2'd2);
        send_index(32'd7);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 69 : 0;
            recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 7 : 0;
            for (int cfgs = 0; cfgs < 8; cfgs++) begin
                random_config();
                for (int n = 0; n < 50; n++) begin
                    send_index(pick_index());
                    // Once per phase, hold off until every address is back.
                    if (n == 25 && cfgs == 3) begin
                        s_axis_tvalid <= 1'b0;
                        @(posedge i_clk);
                        while (sb.pending.size() != 0)
                            @(posedge i_clk);
                    end
                end
                drain();
            end
        end

        send_idle_pct = 0;
        recv_idle_pct = 0;
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (sb.errors == 0 && !timed_out) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

`default_nettype wire

### files.f
hdl/sta_pkg.sv
hdl/sta_div_cell.sv
hdl/sta_axis.sv
hdl/strided_tensor_address.sv
dv/strided_tensor_address_tb.sv
